@@ hw/rtl/bdlp_pkg.sv @@
// Package for the button debounce / long-press / auto-repeat block.
// Holds item types, per-button state entry type, event and phase codes.
// No dependencies.
`default_nettype none

package bdlp_pkg;

    // Field widths
    localparam int BIDX_W  = 3;
    localparam int EVENT_W = 3;
    localparam int PHASE_W = 2;
    localparam int CNT_W   = 16;
    localparam int MASK_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int NUM_BUTTONS_DEF = 8;

    // Register reset values (ticks)
    localparam logic [CNT_W-1:0]  DEBOUNCE_RST   = 16'd100;
    localparam logic [CNT_W-1:0]  LONG_PRESS_RST = 16'd3000;
    localparam logic [CNT_W-1:0]  REPEAT_RST     = 16'd500;
    localparam logic [MASK_W-1:0] MASK_RST       = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 2'd3;

    // Press phase codes (code 3 is treated as released)
    localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REPEAT   = 2'd2;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LONG    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_REPEAT  = 3'd4;

    typedef struct packed {
        logic [BIDX_W-1:0] button_index;
        logic              pin_level;
    } sample_t;

    typedef struct packed {
        logic [EVENT_W-1:0] button_event;
        logic               pressed_now;
        logic [BIDX_W-1:0]  event_button;
    } result_t;

    // One button's state word as kept in the state memory
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]   holdoff;
        logic [CNT_W-1:0]   timeout;
    } entry_t;

    // Timing registers handed to the update logic
    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } timing_t;

endpackage

`default_nettype wire

@@ hw/rtl/bdlp_state_mem.sv @@
// Per-button state memory: synchronous read, one write port, valid bits
// so unwritten entries read as zero, and write-to-read forwarding.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_state_mem #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF,
    parameter int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output bdlp_pkg::entry_t         rd_data,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire bdlp_pkg::entry_t    wr_data
);

    bdlp_pkg::entry_t mem [NUM_BUTTONS];
    bdlp_pkg::entry_t mem_q_reg;

    logic [NUM_BUTTONS-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic [ADDR_W-1:0]      rd_addr_reg;

    // Last write, kept to cover a read issued on the same edge
    logic                   fwd_valid_reg;
    logic [ADDR_W-1:0]      fwd_addr_reg;
    bdlp_pkg::entry_t       fwd_data_reg;

    // Array write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Control: valid bits, read address, forward tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_addr_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_addr_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
                fwd_valid_reg      <= 1'b1;
                fwd_addr_reg       <= wr_addr;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_addr_reg  <= rd_addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // Newest write to this entry wins over the array copy
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
        begin
            rd_data = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bdlp_update.sv @@
// Next-state and event logic for one button tick: debounce hold-off,
// press/release detection, long-press timeout and repeat reload.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_update (
    input  wire bdlp_pkg::entry_t               cur,
    input  wire logic                           active,
    input  wire bdlp_pkg::timing_t              timing,
    output bdlp_pkg::entry_t                    nxt,
    output logic [bdlp_pkg::EVENT_W-1:0]        button_event
);

    logic [bdlp_pkg::PHASE_W-1:0] ph;
    logic [bdlp_pkg::CNT_W-1:0]   tmo_dec;

    assign tmo_dec = cur.timeout - 1'b1;

    always_comb
    begin
        // Unknown phase code behaves as released
        if ((cur.phase == bdlp_pkg::PH_PRESSED) || (cur.phase == bdlp_pkg::PH_REPEAT))
        begin
            ph = cur.phase;
        end
        else
        begin
            ph = bdlp_pkg::PH_RELEASED;
        end

        nxt          = cur;
        button_event = bdlp_pkg::EV_NONE;

        if (cur.holdoff != '0)
        begin
            // Inside hold-off: just count down
            nxt.holdoff = cur.holdoff - 1'b1;
        end
        else if (active && (ph == bdlp_pkg::PH_RELEASED))
        begin
            button_event = bdlp_pkg::EV_PRESS;
            nxt.phase    = bdlp_pkg::PH_PRESSED;
            nxt.timeout  = timing.long_press_ticks;
            nxt.holdoff  = timing.debounce_ticks;
        end
        else if (!active && (ph != bdlp_pkg::PH_RELEASED))
        begin
            button_event = bdlp_pkg::EV_RELEASE;
            nxt.phase    = bdlp_pkg::PH_RELEASED;
            nxt.timeout  = '0;
            nxt.holdoff  = timing.debounce_ticks;
        end
        else if (cur.timeout != '0)
        begin
            nxt.timeout = tmo_dec;
            if (tmo_dec == '0)
            begin
                if (ph == bdlp_pkg::PH_PRESSED)
                begin
                    button_event = bdlp_pkg::EV_LONG;
                    nxt.phase    = bdlp_pkg::PH_REPEAT;
                    nxt.timeout  = timing.repeat_ticks;
                end
                else if (ph == bdlp_pkg::PH_REPEAT)
                begin
                    button_event = bdlp_pkg::EV_REPEAT;
                    nxt.timeout  = timing.repeat_ticks;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/button_debounce_long_press_repeat.sv @@
// Top level of the button debounce / long-press / auto-repeat block.
// Uses bdlp_pkg, bdlp_state_mem and bdlp_update.
// Usage:
//   sample channel (sample_valid/sample_ready/sample) carries one tick
//   sample of one button: its index and raw pin level.
//   result channel (result_valid/result_ready/result) returns exactly one
//   item per sample, in order: event code, pressed_now, button index.
//   cfg_we/cfg_index/cfg_data write the four timing/polarity registers;
//   write them only while no sample is in flight.
// Timing:
//   The accepting edge issues the state memory read; when the compute
//   stage advances, the new state is written back and the result register
//   loads. One sample per cycle sustained while results are taken, any
//   button order: a same-entry read and write share a forward register.
// Reset:
//   Registers return to their defaults; every button reads released with
//   zero counters through per-entry valid bits, so no clearing pass.
// Stall:
//   A stalled result holds; an empty compute stage takes one more item, then
//   sample_ready drops until the result is taken.
`default_nettype none

module button_debounce_long_press_repeat #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            sample_valid,
    output logic                                 sample_ready,
    input  wire bdlp_pkg::sample_t               sample,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output bdlp_pkg::result_t                    result,
    input  wire logic                            cfg_we,
    input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bdlp_pkg::CFG_W-1:0]      cfg_data
);

    localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [bdlp_pkg::BIDX_W:0] NUM_B = (bdlp_pkg::BIDX_W + 1)'(NUM_BUTTONS);

    // Configuration registers
    logic [bdlp_pkg::MASK_W-1:0] active_high_reg;
    bdlp_pkg::timing_t           timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_high_reg             <= bdlp_pkg::MASK_RST;
            timing_reg.debounce_ticks   <= bdlp_pkg::DEBOUNCE_RST;
            timing_reg.long_press_ticks <= bdlp_pkg::LONG_PRESS_RST;
            timing_reg.repeat_ticks     <= bdlp_pkg::REPEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdlp_pkg::CFG_ACTIVE_HIGH:
                    active_high_reg <= cfg_data[bdlp_pkg::MASK_W-1:0];
                bdlp_pkg::CFG_DEBOUNCE:   timing_reg.debounce_ticks   <= cfg_data;
                bdlp_pkg::CFG_LONG_PRESS: timing_reg.long_press_ticks <= cfg_data;
                bdlp_pkg::CFG_REPEAT:     timing_reg.repeat_ticks     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake
    logic              s1_valid_reg;
    bdlp_pkg::sample_t s1_sample_reg;
    logic              s1_adv;
    logic              in_acc;

    assign s1_adv       = !result_valid || result_ready;
    assign sample_ready = !s1_valid_reg || s1_adv;
    assign in_acc       = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s1_adv)
            begin
                result_valid <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sample_reg <= sample;
        end
    end

    // State memory
    bdlp_pkg::entry_t cur_entry;
    bdlp_pkg::entry_t nxt_entry;
    logic             wr_en;

    bdlp_state_mem #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (sample.button_index[ADDR_W-1:0]),
        .rd_data (cur_entry),
        .wr_en   (wr_en),
        .wr_addr (s1_sample_reg.button_index[ADDR_W-1:0]),
        .wr_data (nxt_entry)
    );

    // Compute stage
    logic                          active;
    logic                          in_range;
    logic [bdlp_pkg::EVENT_W-1:0]  upd_event;

    assign active   = (s1_sample_reg.pin_level ==
                       active_high_reg[s1_sample_reg.button_index]);
    assign in_range = ({1'b0, s1_sample_reg.button_index} < NUM_B);
    assign wr_en    = s1_valid_reg && s1_adv && in_range;

    bdlp_update u_upd (
        .cur          (cur_entry),
        .active       (active),
        .timing       (timing_reg),
        .nxt          (nxt_entry),
        .button_event (upd_event)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            result.button_event <= in_range ? upd_event : bdlp_pkg::EV_NONE;
            result.pressed_now  <= active;
            result.event_button <= s1_sample_reg.button_index;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bdlp_checker.sv @@
// Port-level checker for button_debounce_long_press_repeat, bound to it.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              sample_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire bdlp_pkg::result_t result
);

    // Result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Input only back-pressured when the output is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("sample_ready low without output stall");

    // Event code in range
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.button_event <= bdlp_pkg::EV_REPEAT)
        else $error("bad event code");

    // Press, long press and repeat come only with the button held
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.button_event == bdlp_pkg::EV_PRESS) ||
                         (result.button_event == bdlp_pkg::EV_LONG) ||
                         (result.button_event == bdlp_pkg::EV_REPEAT))
        |-> result.pressed_now)
        else $error("held event without pressed level");

    // Release comes only with the button up
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.button_event == bdlp_pkg::EV_RELEASE)
        |-> !result.pressed_now)
        else $error("release event with pressed level");

endmodule

bind button_debounce_long_press_repeat bdlp_checker u_bdlp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
